/* design/kms_pkg.sv */
// ============================================================================
// K-way merge selector package
// Shared field widths, request and status codes, and the sequencer states.
// ============================================================================
package kms_pkg;

   localparam int DATA_W      = 64;
   localparam int WAY_FIELD_W = 3;
   localparam int STATUS_W    = 2;
   localparam int ARITY_W     = 4;

   localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd8;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PUSHED   = 2'd0,
      STATUS_POPPED   = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN
   } state_type;

endpackage

/* design/kms_ram.sv */
// ============================================================================
// K-way merge selector buffer RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ============================================================================
module kms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/kway_merge_selector_core.sv */
// ============================================================================
// K-way merge selector core
// Holds one block of a sorted run per way and merges the runs: a push
// request appends a value to one way, a pop request returns the smallest
// head among the active ways.
// ============================================================================
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------------
//   request   start, busy            req_kind, req_way, req_value
//   response  rsp_strobe (1 cycle)   rsp_status, rsp_merged_value,
//                                    rsp_source_way, rsp_refill_needed
//   config    csr_write_en           csr_active_ways
//
// A push reads the way's bookkeeping entry at the edge that accepts the request
// and writes the value and the new count at the edge after it. A pop scans the
// active ways, arity being active_ways saturated to MAX_WAYS, reading one
// bookkeeping entry per cycle; the read chain through the bookkeeping and block
// memories and the head compare follow behind.
// The response is registered and its strobe rises in the same cycle that busy
// drops, so the next request can be accepted at the edge that takes it.
// Reset (synchronous, active high) clears the sequencer and the per-way valid
// bits and sets the arity register to ARITY_RESET; no clearing pass is needed.
// The receiver cannot stall, so a response is never held back.
//
module kway_merge_selector_core #(
   parameter int MAX_WAYS    = 8,
   parameter int BLOCK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [kms_pkg::WAY_FIELD_W-1:0]     req_way,
   input  logic signed [kms_pkg::DATA_W-1:0]   req_value,
   // response channel
   output logic                                rsp_strobe,
   output logic [kms_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [kms_pkg::DATA_W-1:0]   rsp_merged_value,
   output logic [kms_pkg::WAY_FIELD_W-1:0]     rsp_source_way,
   output logic                                rsp_refill_needed,
   // configuration
   input  logic                                csr_write_en,
   input  logic [kms_pkg::ARITY_W-1:0]         csr_active_ways
);

   import kms_pkg::*;

   // Per-way bookkeeping word is {fill count, read position}.
   localparam int WAY_W  = $clog2(MAX_WAYS);
   localparam int POS_W  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int FILL_W = $clog2(BLOCK_DEPTH + 1);
   localparam int META_W = FILL_W + POS_W;
   localparam int CNT_W  = $clog2(MAX_WAYS + 1);
   localparam int STORE_DEPTH = MAX_WAYS * BLOCK_DEPTH;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Base address of a way's block inside the block memory.
   function automatic logic [ADDR_W-1:0] way_base(input logic [WAY_W-1:0] w);
      return ADDR_W'(w) * ADDR_W'(BLOCK_DEPTH);
   endfunction

   // Sequencer and request capture
   state_type               state_ff, state_in;
   logic [ARITY_W-1:0]      active_ways_ff, active_ways_in;
   logic [WAY_FIELD_W-1:0]  way_ff, way_in;
   logic [DATA_W-1:0]       value_ff, value_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic [CNT_W-1:0]        limit_now;

   // Scan pipeline: rd_idx issues bookkeeping reads, stage 1 holds the
   // bookkeeping data and issues the head read, stage 2 compares the head.
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    p1_vld_ff, p1_vld_in;
   logic [WAY_W-1:0]        p1_way_ff, p1_way_in;
   logic                    p2_vld_ff, p2_vld_in;
   logic [WAY_W-1:0]        p2_way_ff, p2_way_in;
   logic [POS_W-1:0]        p2_pos_ff, p2_pos_in;
   logic [FILL_W-1:0]       p2_fill_ff, p2_fill_in;

   // Running minimum of the scan
   logic                    found_ff, found_in;
   logic [WAY_W-1:0]        best_way_ff, best_way_in;
   logic [DATA_W-1:0]       best_val_ff, best_val_in;
   logic [POS_W-1:0]        best_pos_ff, best_pos_in;
   logic [FILL_W-1:0]       best_fill_ff, best_fill_in;

   // Bookkeeping entries that were never written read as zero.
   logic [MAX_WAYS-1:0]     meta_valid_ff, meta_valid_in;
   logic                    meta_rd_valid_ff;

   // Response registers
   logic                    rsp_strobe_ff, rsp_strobe_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [WAY_FIELD_W-1:0]  rsp_way_ff, rsp_way_in;
   logic                    rsp_refill_ff, rsp_refill_in;

   // Memory ports
   logic                    meta_we, meta_re;
   logic [WAY_W-1:0]        meta_waddr, meta_raddr;
   logic [META_W-1:0]       meta_wdata, meta_rdata, meta_q;
   logic                    store_we, store_re;
   logic [ADDR_W-1:0]       store_waddr, store_raddr;
   logic [DATA_W-1:0]       store_wdata, store_rdata;

   // Decoded bookkeeping word and scan control
   logic [FILL_W-1:0]       cur_fill;
   logic [POS_W-1:0]        cur_pos;
   logic                    issue;
   logic                    head_hit;
   logic                    scan_done;
   logic                    push_reject;
   logic [FILL_W-1:0]       next_pos;
   logic                    drained;

   kms_ram #(
      .WIDTH (META_W),
      .DEPTH (MAX_WAYS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   kms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   // The bookkeeping read and its valid bit come back together.
   assign meta_q   = meta_rd_valid_ff ? meta_rdata : '0;
   assign cur_fill = meta_q[META_W-1:POS_W];
   assign cur_pos  = meta_q[POS_W-1:0];

   // Effective arity is the register saturated to the number of ways.
   always_comb begin
      if (int'(active_ways_ff) > MAX_WAYS) begin
         limit_now = CNT_W'(MAX_WAYS);
      end else begin
         limit_now = CNT_W'(active_ways_ff);
      end
   end

   assign issue     = (rd_idx_ff < limit_ff);
   assign head_hit  = p1_vld_ff && (FILL_W'(cur_pos) < cur_fill);
   assign scan_done = !issue && !p1_vld_ff && !p2_vld_ff;

   // A push is refused for a way beyond the store or a full block.
   assign push_reject = (int'(way_ff) >= MAX_WAYS) ||
                        (cur_fill >= FILL_W'(BLOCK_DEPTH));

   // After a pop the source way advances; consuming its last entry empties it.
   assign next_pos = FILL_W'(best_pos_ff) + FILL_W'(1);
   assign drained  = (next_pos >= best_fill_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_kind == KIND_POP) ? ST_SCAN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory accesses and response
   always_comb begin
      active_ways_in = active_ways_ff;
      way_in         = way_ff;
      value_in       = value_ff;
      limit_in       = limit_ff;
      rd_idx_in      = rd_idx_ff;
      p1_vld_in      = 1'b0;
      p1_way_in      = p1_way_ff;
      p2_vld_in      = 1'b0;
      p2_way_in      = p2_way_ff;
      p2_pos_in      = p2_pos_ff;
      p2_fill_in     = p2_fill_ff;
      found_in       = found_ff;
      best_way_in    = best_way_ff;
      best_val_in    = best_val_ff;
      best_pos_in    = best_pos_ff;
      best_fill_in   = best_fill_ff;
      meta_valid_in  = meta_valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_refill_in  = rsp_refill_ff;

      meta_we     = 1'b0;
      meta_waddr  = best_way_ff;
      meta_wdata  = '0;
      meta_re     = 1'b0;
      meta_raddr  = rd_idx_ff[WAY_W-1:0];
      store_we    = 1'b0;
      store_waddr = way_base(WAY_W'(way_ff)) + ADDR_W'(cur_fill[POS_W-1:0]);
      store_wdata = value_ff;
      store_re    = 1'b0;
      store_raddr = way_base(p1_way_ff) + ADDR_W'(cur_pos);

      if (csr_write_en) begin
         active_ways_in = csr_active_ways;
      end

      case (state_ff)
         ST_IDLE: begin
            meta_raddr = WAY_W'(req_way);
            if (start) begin
               way_in    = req_way;
               value_in  = req_value;
               limit_in  = limit_now;
               rd_idx_in = '0;
               found_in  = 1'b0;
               meta_re   = (req_kind == KIND_PUSH);
            end
         end

         ST_PUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_way_in    = way_ff;
            rsp_refill_in = 1'b0;
            if (push_reject) begin
               rsp_status_in = STATUS_REJECTED;
            end else begin
               rsp_status_in = STATUS_PUSHED;
               store_we      = 1'b1;
               meta_we       = 1'b1;
               meta_waddr    = WAY_W'(way_ff);
               meta_wdata    = {cur_fill + FILL_W'(1), cur_pos};
               meta_valid_in[WAY_W'(way_ff)] = 1'b1;
            end
         end

         ST_SCAN: begin
            // Issue the bookkeeping read of the next way.
            if (issue) begin
               meta_re   = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               p1_vld_in = 1'b1;
               p1_way_in = rd_idx_ff[WAY_W-1:0];
            end
            // A way with a loaded entry has its head fetched.
            if (head_hit) begin
               store_re   = 1'b1;
               p2_vld_in  = 1'b1;
               p2_way_in  = p1_way_ff;
               p2_pos_in  = cur_pos;
               p2_fill_in = cur_fill;
            end
            // Strict less-than keeps the lowest way on equal heads.
            if (p2_vld_ff &&
                (!found_ff || ($signed(store_rdata) < $signed(best_val_ff)))) begin
               found_in     = 1'b1;
               best_way_in  = p2_way_ff;
               best_val_in  = store_rdata;
               best_pos_in  = p2_pos_ff;
               best_fill_in = p2_fill_ff;
            end
            if (scan_done) begin
               rsp_strobe_in = 1'b1;
               if (found_ff) begin
                  rsp_status_in = STATUS_POPPED;
                  rsp_value_in  = best_val_ff;
                  rsp_way_in    = WAY_FIELD_W'(best_way_ff);
                  rsp_refill_in = drained;
                  meta_we       = 1'b1;
                  meta_waddr    = best_way_ff;
                  meta_wdata    = drained ? '0 : {best_fill_ff, next_pos[POS_W-1:0]};
               end else begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_value_in  = '0;
                  rsp_way_in    = '0;
                  rsp_refill_in = 1'b0;
               end
            end
         end

         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         active_ways_ff   <= ARITY_RESET;
         meta_valid_ff    <= '0;
         meta_rd_valid_ff <= 1'b0;
         p1_vld_ff        <= 1'b0;
         p2_vld_ff        <= 1'b0;
         found_ff         <= 1'b0;
         rd_idx_ff        <= '0;
         limit_ff         <= '0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ways_ff <= active_ways_in;
         meta_valid_ff  <= meta_valid_in;
         if (meta_re) begin
            meta_rd_valid_ff <= meta_valid_ff[meta_raddr];
         end
         p1_vld_ff     <= p1_vld_in;
         p2_vld_ff     <= p2_vld_in;
         found_ff      <= found_in;
         rd_idx_ff     <= rd_idx_in;
         limit_ff      <= limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      way_ff        <= way_in;
      value_ff      <= value_in;
      p1_way_ff     <= p1_way_in;
      p2_way_ff     <= p2_way_in;
      p2_pos_ff     <= p2_pos_in;
      p2_fill_ff    <= p2_fill_in;
      best_way_ff   <= best_way_in;
      best_val_ff   <= best_val_in;
      best_pos_ff   <= best_pos_in;
      best_fill_ff  <= best_fill_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_refill_ff <= rsp_refill_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_merged_value  = rsp_value_ff;
   assign rsp_source_way    = rsp_way_ff;
   assign rsp_refill_needed = rsp_refill_ff;

endmodule

/* design/kms_checker.sv */
// ============================================================================
// K-way merge selector port checker
// Watches the core's ports over time and flags request and response slips.
// ============================================================================
module kms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic [kms_pkg::STATUS_W-1:0]      rsp_status,
   input logic [kms_pkg::DATA_W-1:0]        rsp_merged_value,
   input logic [kms_pkg::WAY_FIELD_W-1:0]   rsp_source_way,
   input logic                              rsp_refill_needed
);

   import kms_pkg::*;

   // An accepted request always raises busy in the cycle after it is accepted.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The core goes idle only when it has a response to show.
   a_idle_response: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("core went idle without a response");

   // A response is shown only while the core is idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // Only a pop carries a value or a refill flag.
   a_non_pop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_POPPED)) |->
         ((rsp_merged_value == '0) && !rsp_refill_needed))
      else $error("non-pop response carries value or refill");

   // An empty merge names no source way.
   a_empty_way: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_EMPTY)) |-> (rsp_source_way == '0))
      else $error("empty response with nonzero way");

endmodule

bind kway_merge_selector_core kms_checker u_kms_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_merged_value  (rsp_merged_value),
   .rsp_source_way    (rsp_source_way),
   .rsp_refill_needed (rsp_refill_needed)
);
